### src/generational_handle_table_assert.svh
// Assertion macros shared by the checker of the generational handle table.
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ght_pkg.sv
// Types and constants of the generational handle table.
package ght_pkg;

    localparam int unsigned HANDLE_W = 24;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned WIDE_W   = 64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

endpackage

### src/ght_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ght_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/generational_handle_table.sv
// Generational handle table: a slot map that hands out tagged handles.
// A command word is taken whenever start is high and busy is low, which is every cycle
// once reset has been released, and its result word appears with o_result_valid for
// exactly one cycle, via the execute register (r_vld) and the result register
// (r_res_vld); the receiver cannot hold results off, so one word per cycle must be
// absorbed. The execute stage uses the registered reads of the slot RAM (data and
// tag) and of the free-slot stack RAM, addressed at the accepting edge and resolved in
// the following cycle, with the write of the previous command forwarded around each
// RAM. Valid bits, the free-stack count, the high-water mark and the generation counter
// live in flip-flops. After reset every slot reads as unused; no clearing pass is needed.
module generational_handle_table #(
    parameter int unsigned CAPACITY  = 256,
    parameter int unsigned TAG_BITS  = 16,
    parameter int unsigned DATA_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ght_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [DATA_BITS-1:0]          i_data_in,
    input  logic [ght_pkg::HANDLE_W-1:0]  i_handle_in,
    output logic                          o_result_valid,
    output logic [ght_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic [DATA_BITS-1:0]          o_data_out,
    output logic [ght_pkg::STATUS_W-1:0]  o_status
);

    import ght_pkg::*;

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned SL_W  = DATA_BITS + TAG_BITS;

    // Execute stage inputs
    logic                 r_vld;
    logic [OPCODE_W-1:0]  r_opcode;
    logic [DATA_BITS-1:0] r_data;
    logic [HANDLE_W-1:0]  r_handle;

    // Table state
    logic [CNT_W-1:0]     r_free_count, n_free_count;
    logic [CNT_W-1:0]     r_high_water, n_high_water;
    logic [TAG_BITS-1:0]  r_gen, n_gen;
    logic [CAPACITY-1:0]  r_valid, n_valid;

    // Forwarding around the RAMs
    logic                 r_sl_fwd;
    logic [DATA_BITS-1:0] r_fwd_data;
    logic [TAG_BITS-1:0]  r_fwd_tag;
    logic                 r_fs_fwd;
    logic [IDX_W-1:0]     r_fs_fwd_slot;

    // Result word
    logic                 r_res_vld;
    logic [HANDLE_W-1:0]  r_handle_out, n_handle_out;
    logic [DATA_BITS-1:0] r_data_out, n_data_out;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic                 accept;
    logic [WIDE_W-1:0]    in_slot_w;
    logic [WIDE_W-1:0]    lk_slot_w;
    logic [IDX_W-1:0]     lk_idx;
    logic [TAG_BITS-1:0]  lk_tag;
    logic                 in_range;
    logic                 hit;

    logic [IDX_W-1:0]     sl_raddr;
    logic [SL_W-1:0]      sl_rdata;
    logic                 sl_we;
    logic [IDX_W-1:0]     sl_waddr;
    logic [DATA_BITS-1:0] cur_data;
    logic [TAG_BITS-1:0]  cur_tag;

    logic [CNT_W-1:0]     fs_top_cnt;
    logic [IDX_W-1:0]     fs_raddr;
    logic [IDX_W-1:0]     fs_rdata;
    logic [IDX_W-1:0]     fs_top;
    logic                 fs_we;
    logic [IDX_W-1:0]     fs_waddr;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Read addresses are presented at the accepting edge.
    assign in_slot_w  = WIDE_W'(i_handle_in) >> TAG_BITS;
    assign sl_raddr   = in_slot_w[IDX_W-1:0];
    assign fs_top_cnt = n_free_count - CNT_W'(1);
    assign fs_raddr   = fs_top_cnt[IDX_W-1:0];

    assign lk_slot_w = WIDE_W'(r_handle) >> TAG_BITS;
    assign lk_idx    = lk_slot_w[IDX_W-1:0];
    assign lk_tag    = TAG_BITS'(r_handle);
    // The high-water mark never exceeds the capacity, so this also bounds the slot.
    assign in_range  = lk_slot_w < WIDE_W'(r_high_water);

    assign cur_data = r_sl_fwd ? r_fwd_data : sl_rdata[SL_W-1:TAG_BITS];
    assign cur_tag  = r_sl_fwd ? r_fwd_tag  : sl_rdata[TAG_BITS-1:0];
    assign fs_top   = r_fs_fwd ? r_fs_fwd_slot : fs_rdata;
    assign hit      = in_range && r_valid[lk_idx] && (cur_tag == lk_tag);

    always_comb begin
        n_free_count = r_free_count;
        n_high_water = r_high_water;
        n_gen        = r_gen;
        n_valid      = r_valid;
        sl_we        = 1'b0;
        sl_waddr     = fs_top;
        fs_we        = 1'b0;
        fs_waddr     = r_free_count[IDX_W-1:0];
        n_handle_out = '0;
        n_data_out   = '0;
        n_status     = ST_MISS;
        if (r_vld) begin
            unique case (r_opcode)
                OP_ADD: begin
                    if (r_free_count != '0) begin
                        // Reuse the most recently freed slot.
                        sl_we        = 1'b1;
                        sl_waddr     = fs_top;
                        n_free_count = r_free_count - CNT_W'(1);
                    end else if (r_high_water < CNT_W'(CAPACITY)) begin
                        sl_we        = 1'b1;
                        sl_waddr     = r_high_water[IDX_W-1:0];
                        n_high_water = r_high_water + CNT_W'(1);
                    end
                    if (sl_we) begin
                        n_gen             = r_gen + TAG_BITS'(1);
                        n_valid[sl_waddr] = 1'b1;
                        n_handle_out      = HANDLE_W'((WIDE_W'(sl_waddr) << TAG_BITS)
                                                      | WIDE_W'(n_gen));
                        n_status          = ST_OK;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                OP_GET: begin
                    if (hit) begin
                        n_data_out = cur_data;
                        n_status   = ST_OK;
                    end
                end
                OP_REMOVE: begin
                    if (hit) begin
                        n_data_out      = cur_data;
                        n_valid[lk_idx] = 1'b0;
                        n_status        = ST_OK;
                        if (r_free_count < CNT_W'(CAPACITY)) begin
                            fs_we        = 1'b1;
                            n_free_count = r_free_count + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    n_status = ST_MISS;
                end
            endcase
        end
    end

    ght_ram #(
        .WIDTH (SL_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (sl_waddr),
        .i_wdata ({r_data, n_gen}),
        .i_raddr (sl_raddr),
        .o_rdata (sl_rdata)
    );

    ght_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (lk_idx),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= 1'b0;
            r_free_count <= '0;
            r_high_water <= '0;
            r_gen        <= '0;
            r_valid      <= '0;
            r_sl_fwd     <= 1'b0;
            r_fs_fwd     <= 1'b0;
            r_res_vld    <= 1'b0;
        end else begin
            r_vld        <= accept;
            r_free_count <= n_free_count;
            r_high_water <= n_high_water;
            r_gen        <= n_gen;
            r_valid      <= n_valid;
            // A read at the same edge as a write to the same entry sees old contents.
            r_sl_fwd     <= accept && sl_we && (sl_raddr == sl_waddr);
            r_fs_fwd     <= accept && fs_we;
            r_res_vld    <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode <= i_opcode;
            r_data   <= i_data_in;
            r_handle <= i_handle_in;
        end
        r_fwd_data    <= r_data;
        r_fwd_tag     <= n_gen;
        r_fs_fwd_slot <= lk_idx;
        r_handle_out  <= n_handle_out;
        r_data_out    <= n_data_out;
        r_status      <= n_status;
    end

    assign o_result_valid = r_res_vld;
    assign o_handle_out   = r_handle_out;
    assign o_data_out     = r_data_out;
    assign o_status       = r_status;

endmodule

### src/ght_checker.sv
// Port-level checker of the generational handle table and its bind.
`include "generational_handle_table_assert.svh"

module ght_checker #(
    parameter int unsigned DATA_BITS = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [ght_pkg::OPCODE_W-1:0]  i_opcode,
    input logic                          o_result_valid,
    input logic [ght_pkg::HANDLE_W-1:0]  o_handle_out,
    input logic [DATA_BITS-1:0]          o_data_out,
    input logic [ght_pkg::STATUS_W-1:0]  o_status
);

    import ght_pkg::*;

    logic took;
    logic took_add;

    assign took     = start && !busy;
    assign took_add = took && (i_opcode == OP_ADD);

    // Every accepted word gives exactly one result word, and every result word has an accepted command behind it.
    `GHT_ASSERT_NOW(a_result_latency, i_clk, i_rst_n, o_result_valid, $past(took, 2), "result word without a command two cycles earlier")
    `GHT_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, took, ##1 o_result_valid, "accepted command produced no result word")
    // A failed operation returns no handle and no data.
    `GHT_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_result_valid && (o_status != ST_OK), (o_handle_out == '0) && (o_data_out == '0), "failed operation returned a handle or data")
    // Only an add can report a full table, and an add never returns data.
    `GHT_ASSERT_NOW(a_add_shape, i_clk, i_rst_n, o_result_valid && ((o_status == ST_FULL) || $past(took_add, 2)), $past(took_add, 2) && (o_data_out == '0), "add result has the wrong shape")

endmodule

bind generational_handle_table ght_checker #(
    .DATA_BITS (DATA_BITS)
) u_ght_checker (.*);
